[rtl/core/mact_pkg.sv]
// Shared types, register indexes, reset values and sequencer codes of the crossover trader.
package mact_pkg;

  localparam int MAX_WINDOW_DEF = 256;

  localparam int TIME_W     = 48;
  localparam int PX_W       = 24;
  localparam int POS_W      = 16;
  localparam int QTY_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int STEP_W     = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LEN  = 3'd6;

  // Register values after reset.
  localparam logic [15:0]       RST_THRESHOLD = 16'd512;
  localparam logic [14:0]       RST_POS_LIMIT = 15'd30;
  localparam logic [TIME_W-1:0] RST_SAMPLE    = 48'd1000000;
  localparam logic [TIME_W-1:0] RST_COOLDOWN  = 48'd10000000;
  localparam logic [15:0]       RST_CHUNK     = 16'd5;
  localparam logic [8:0]        RST_FAST_LEN  = 9'd20;
  localparam logic [8:0]        RST_SLOW_LEN  = 9'd200;

  typedef struct packed {
    logic [TIME_W-1:0]       now_ns;
    logic [PX_W-1:0]         fair_px;
    logic signed [POS_W-1:0] position;
    logic                    has_bid;
    logic [PX_W-1:0]         bid_px;
    logic                    has_ask;
    logic [PX_W-1:0]         ask_px;
  } tick_t;

  typedef struct packed {
    logic             order_valid;
    logic             order_side;
    logic [PX_W-1:0]  order_price;
    logic [QTY_W-1:0] order_qty;
  } order_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_RD_SLOW,
    OP_UPD_SLOW,
    OP_MUL_FS,
    OP_MUL_SS,
    OP_MUL_TH,
    OP_MUL_TN,
    OP_DECIDE,
    OP_EMIT
  } dp_op_t;

  // Jump conditions of the sequencer.
  typedef enum logic [1:0] {
    C_NONE,
    C_NO_SAMPLE,
    C_NO_ORDER,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t            op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              done;
  } ctl_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic no_sample;
    logic no_order;
    logic out_busy;
  } stat_t;

endpackage

[rtl/core/mact_if.sv]
// Valid/ready channel interfaces for market ticks and order results.
interface mact_tick_if;
  logic        valid;
  logic        ready;
  logic [47:0] now_ns;
  logic [23:0] fair_px;
  logic signed [15:0] position;
  logic        has_bid;
  logic [23:0] bid_px;
  logic        has_ask;
  logic [23:0] ask_px;

  modport source (output valid, now_ns, fair_px, position, has_bid, bid_px, has_ask, ask_px,
                  input ready);
  modport sink (input valid, now_ns, fair_px, position, has_bid, bid_px, has_ask, ask_px,
                output ready);
endinterface

interface mact_order_if;
  logic        valid;
  logic        ready;
  logic        order_valid;
  logic        order_side;
  logic [23:0] order_price;
  logic [15:0] order_qty;

  modport source (output valid, order_valid, order_side, order_price, order_qty,
                  input ready);
  modport sink (input valid, order_valid, order_side, order_price, order_qty,
                output ready);
endinterface

[rtl/core/ma_crossover_signal_trader.sv]
// Top level of the moving-average crossover trader: channels, sequencer and datapath.
//
// Each accepted tick word yields exactly one order word, with order_valid low and all other
// fields zero when no order goes out. A tick is worked on by a microcoded sequencer that
// steps a small datapath through a ten-word program: a tick that takes no sample jumps from
// the sample step straight to the emit step, one that takes a sample but is held back by
// the window fill or the cooldown jumps there after the ring update, and one that reaches
// the order decision runs every step. The full path is set by the single read port of the
// sample ring (two oldest entries are read one after the other before the new sample is
// written) and by the one shared multiplier that forms the four products of the exact
// crossover compare. The finished order word sits in an output register, so a new tick is
// accepted while it still waits to be taken; only the final step of the next tick stalls
// on it. No clearing pass runs after reset: the window logic only reads ring entries
// written since the last clear. Writing fast_length or slow_length empties the window.
module ma_crossover_signal_trader import mact_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input logic                  clk,
  input logic                  rst,
  mact_tick_if.sink            tick,
  mact_order_if.source         order,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  tick_t  tick_data;
  order_t out_data;
  stat_t  stat;
  dp_op_t op;
  logic   busy;
  logic   start;
  logic   out_valid;

  // A tick word is taken whenever the sequencer has no program running.
  assign tick.ready = !busy;
  assign start      = tick.valid && !busy;

  assign tick_data.now_ns   = tick.now_ns;
  assign tick_data.fair_px  = tick.fair_px;
  assign tick_data.position = tick.position;
  assign tick_data.has_bid  = tick.has_bid;
  assign tick_data.bid_px   = tick.bid_px;
  assign tick_data.has_ask  = tick.has_ask;
  assign tick_data.ask_px   = tick.ask_px;

  mact_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  mact_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .start     (start),
    .tick_data (tick_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (order.ready),
    .out_data  (out_data)
  );

  assign order.valid       = out_valid;
  assign order.order_valid = out_data.order_valid;
  assign order.order_side  = out_data.order_side;
  assign order.order_price = out_data.order_price;
  assign order.order_qty   = out_data.order_qty;

  // Once a tick is taken, the sequencer holds off the next one while its program runs.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> !tick.ready)
    else $error("tick accepted while the previous program was still starting");

  // An order word without an order carries no side, price or quantity.
  a_no_order_zero: assert property (@(posedge clk) disable iff (rst)
    (order.valid && !order.order_valid) |->
      (!order.order_side && order.order_price == '0 && order.order_qty == '0))
    else $error("empty order word with nonzero fields");

  // A new order word is loaded only from the final program step.
  a_emit_step: assert property (@(posedge clk) disable iff (rst)
    ($rose(order.valid)) |-> $past(op == OP_EMIT))
    else $error("order word appeared outside the emit step");

endmodule

[rtl/core/mact_seq.sv]
// Microcode sequencer: control ROM, step counter and conditional jumps.
module mact_seq import mact_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  stat_t  stat,
  output dp_op_t op,
  output logic   busy
);

  localparam logic [STEP_W-1:0] ST_SAMPLE   = 4'd0;
  localparam logic [STEP_W-1:0] ST_RD_SLOW  = 4'd1;
  localparam logic [STEP_W-1:0] ST_UPD_SLOW = 4'd2;
  localparam logic [STEP_W-1:0] ST_CHK_ORD  = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_FS   = 4'd4;
  localparam logic [STEP_W-1:0] ST_MUL_SS   = 4'd5;
  localparam logic [STEP_W-1:0] ST_MUL_TH   = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL_TN   = 4'd7;
  localparam logic [STEP_W-1:0] ST_DECIDE   = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT     = 4'd9;

  function automatic ctl_t rom(logic [STEP_W-1:0] s);
    ctl_t c;
    unique case (s)
      ST_SAMPLE:   c = '{OP_SAMPLE,   C_NO_SAMPLE, ST_EMIT, 1'b0};
      ST_RD_SLOW:  c = '{OP_RD_SLOW,  C_NONE,      ST_EMIT, 1'b0};
      ST_UPD_SLOW: c = '{OP_UPD_SLOW, C_NONE,      ST_EMIT, 1'b0};
      ST_CHK_ORD:  c = '{OP_NONE,     C_NO_ORDER,  ST_EMIT, 1'b0};
      ST_MUL_FS:   c = '{OP_MUL_FS,   C_NONE,      ST_EMIT, 1'b0};
      ST_MUL_SS:   c = '{OP_MUL_SS,   C_NONE,      ST_EMIT, 1'b0};
      ST_MUL_TH:   c = '{OP_MUL_TH,   C_NONE,      ST_EMIT, 1'b0};
      ST_MUL_TN:   c = '{OP_MUL_TN,   C_NONE,      ST_EMIT, 1'b0};
      ST_DECIDE:   c = '{OP_DECIDE,   C_NONE,      ST_EMIT, 1'b0};
      ST_EMIT:     c = '{OP_EMIT,     C_OUT_BUSY,  ST_EMIT, 1'b1};
      default:     c = '{OP_NONE,     C_NONE,      ST_EMIT, 1'b1};
    endcase
    return c;
  endfunction

  logic [STEP_W-1:0] step;
  ctl_t              ctl;
  logic              jump;

  assign ctl = rom(step);
  assign op  = busy ? ctl.op : OP_NONE;

  always_comb begin
    unique case (ctl.cond)
      C_NONE:      jump = 1'b0;
      C_NO_SAMPLE: jump = stat.no_sample;
      C_NO_ORDER:  jump = stat.no_order;
      C_OUT_BUSY:  jump = stat.out_busy;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_SAMPLE;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= ST_SAMPLE;
      end
    end else if (jump) begin
      step <= ctl.target;
    end else if (ctl.done) begin
      busy <= 1'b0;
    end else begin
      step <= step + 1'b1;
    end
  end

endmodule

[rtl/core/mact_dp.sv]
// Datapath: configuration, sample ring, window sums, shared multiplier and order decision.
module mact_dp import mact_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_op_t                op,
  input  logic                  start,
  input  tick_t                 tick_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output order_t                out_data
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int SW = PX_W + AW;
  localparam int PW = SW + LW;
  localparam int CW = PW + 10;

  function automatic logic passed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last,
                                  logic [TIME_W-1:0] period);
    return (now >= last) && ((now - last) >= period);
  endfunction

  function automatic logic [AW-1:0] oldest(logic [AW-1:0] p, logic [LW-1:0] len);
    logic [LW:0] t;
    t = (LW+1)'(p) + (LW+1)'(MAX_WINDOW) - (LW+1)'(len);
    if (t >= (LW+1)'(MAX_WINDOW)) t = t - (LW+1)'(MAX_WINDOW);
    return t[AW-1:0];
  endfunction

  // Configuration registers.
  logic [15:0]       threshold_q8;
  logic [14:0]       position_limit;
  logic [TIME_W-1:0] sample_period_ns;
  logic [TIME_W-1:0] cooldown_ns;
  logic [15:0]       chunk_size;
  logic [8:0]        fast_length;
  logic [8:0]        slow_length;
  logic              win_clear;

  assign win_clear = cfg_we && ((cfg_index == REG_FAST_LEN) || (cfg_index == REG_SLOW_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_q8     <= RST_THRESHOLD;
      position_limit   <= RST_POS_LIMIT;
      sample_period_ns <= RST_SAMPLE;
      cooldown_ns      <= RST_COOLDOWN;
      chunk_size       <= RST_CHUNK;
      fast_length      <= RST_FAST_LEN;
      slow_length      <= RST_SLOW_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold_q8     <= cfg_data[15:0];
        REG_POS_LIMIT: position_limit   <= cfg_data[14:0];
        REG_SAMPLE:    sample_period_ns <= cfg_data[TIME_W-1:0];
        REG_COOLDOWN:  cooldown_ns      <= cfg_data[TIME_W-1:0];
        REG_CHUNK:     chunk_size       <= cfg_data[15:0];
        REG_FAST_LEN:  fast_length      <= cfg_data[8:0];
        REG_SLOW_LEN:  slow_length      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Latched tick and window state.
  tick_t             tk;
  logic [TIME_W-1:0] last_sample_time;
  logic [TIME_W-1:0] last_order_time;
  logic [AW-1:0]     ring_pointer;
  logic [LW-1:0]     samples_held;
  logic [SW-1:0]     fast_sum;
  logic [SW-1:0]     slow_sum;
  logic [PX_W-1:0]   sample_ring [MAX_WINDOW];
  logic [PX_W-1:0]   rdata;
  logic [AW-1:0]     raddr;
  logic [LW-1:0]     eff_fast;
  logic [LW-1:0]     eff_slow;
  logic [LW-1:0]     fast_used;
  logic [SW-1:0]     fast_drop;
  logic [SW-1:0]     slow_drop;

  assign eff_fast = (fast_length == 9'd0) ? LW'(1) :
                    (32'(fast_length) > 32'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : LW'(fast_length);
  assign eff_slow = (slow_length < 9'd2) ? LW'(2) :
                    (32'(slow_length) > 32'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : LW'(slow_length);
  assign fast_used = (eff_fast > samples_held) ? samples_held : eff_fast;

  assign raddr = (op == OP_RD_SLOW) ? oldest(ring_pointer, eff_slow)
                                    : oldest(ring_pointer, eff_fast);
  assign fast_drop = (samples_held >= eff_fast) ? SW'(rdata) : '0;
  assign slow_drop = (samples_held >= eff_slow) ? SW'(rdata) : '0;

  assign stat.no_sample = !passed(tk.now_ns, last_sample_time, sample_period_ns);
  assign stat.no_order  = (samples_held < eff_slow) ||
                          !passed(tk.now_ns, last_order_time, cooldown_ns);
  assign stat.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (start) tk <= tick_data;
  end

  always_ff @(posedge clk) begin
    if (op == OP_UPD_SLOW) sample_ring[ring_pointer] <= tk.fair_px;
    rdata <= sample_ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || win_clear) begin
      ring_pointer <= '0;
      samples_held <= '0;
      fast_sum     <= '0;
      slow_sum     <= '0;
    end else begin
      case (op)
        OP_RD_SLOW: fast_sum <= fast_sum - fast_drop + SW'(tk.fair_px);
        OP_UPD_SLOW: begin
          slow_sum     <= slow_sum - slow_drop + SW'(tk.fair_px);
          ring_pointer <= (ring_pointer == AW'(MAX_WINDOW - 1)) ? '0 : ring_pointer + 1'b1;
          if (samples_held < LW'(MAX_WINDOW)) samples_held <= samples_held + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // One multiplier shared by the four products of the comparison.
  logic [SW-1:0]    mul_a;
  logic [LW-1:0]    mul_b;
  logic [PW-1:0]    product;
  logic [PW-1:0]    fs_ns;
  logic [PW-1:0]    ss_nf;
  logic [PW-1:0]    th_nf;
  logic [PW-1:0]    th_full;
  logic signed [PW:0] dd;

  always_comb begin
    case (op)
      OP_MUL_FS: begin mul_a = fast_sum;            mul_b = eff_slow;  end
      OP_MUL_SS: begin mul_a = slow_sum;            mul_b = fast_used; end
      OP_MUL_TH: begin mul_a = SW'(threshold_q8);   mul_b = fast_used; end
      OP_MUL_TN: begin mul_a = th_nf[SW-1:0];       mul_b = eff_slow;  end
      default:   begin mul_a = '0;                  mul_b = '0;        end
    endcase
  end

  assign product = {{LW{1'b0}}, mul_a} * {{SW{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    case (op)
      OP_MUL_FS: fs_ns <= product;
      OP_MUL_SS: ss_nf <= product;
      OP_MUL_TH: th_nf <= product;
      OP_MUL_TN: begin
        th_full <= product;
        dd      <= $signed({1'b0, fs_ns}) - $signed({1'b0, ss_nf});
      end
      default: ;
    endcase
  end

  // Target position and order toward it.
  logic signed [CW-1:0] scaled;
  logic signed [CW-1:0] thr_s;
  logic signed [17:0]   pos_x;
  logic signed [17:0]   lim_x;
  logic signed [17:0]   want;
  logic signed [17:0]   gap;
  logic signed [17:0]   neg_gap;
  logic [16:0]          mag;
  logic                 dd_pos;
  logic                 dd_neg;
  order_t               dec;
  order_t               res;

  assign scaled  = $signed({{(CW-PW-1){dd[PW]}}, dd}) <<< 8;
  assign thr_s   = $signed({{(CW-PW){1'b0}}, th_full});
  assign pos_x   = $signed({{2{tk.position[POS_W-1]}}, tk.position});
  assign lim_x   = $signed({3'b000, position_limit});
  assign dd_pos  = !dd[PW] && (dd != '0);
  assign dd_neg  = dd[PW];
  assign gap     = want - pos_x;
  assign neg_gap = -gap;

  always_comb begin
    if (scaled > thr_s) begin
      want = lim_x;
    end else if (scaled < -thr_s) begin
      want = -lim_x;
    end else if ((dd_pos && !pos_x[17] && pos_x != '0) || (dd_neg && pos_x[17])) begin
      want = pos_x;
    end else begin
      want = '0;
    end
  end

  always_comb begin
    dec = '0;
    mag = '0;
    if (!gap[17] && (gap != '0) && tk.has_ask) begin
      mag             = gap[16:0];
      dec.order_valid = 1'b1;
      dec.order_side  = 1'b0;
      dec.order_price = tk.ask_px;
    end else if (gap[17] && tk.has_bid) begin
      mag             = neg_gap[16:0];
      dec.order_valid = 1'b1;
      dec.order_side  = 1'b1;
      dec.order_price = tk.bid_px;
    end
    if (dec.order_valid) dec.order_qty = (mag < {1'b0, chunk_size}) ? mag[15:0] : chunk_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      last_order_time  <= '0;
    end else begin
      if (op == OP_SAMPLE && !stat.no_sample) last_sample_time <= tk.now_ns;
      if (op == OP_DECIDE && dec.order_valid) last_order_time <= tk.now_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (start) res <= '0;
    else if (op == OP_DECIDE) res <= dec;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT && !stat.out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && !stat.out_busy) out_data <= res;
  end

endmodule
